/* hdl/clr_pkg.sv */
// Shared types and constants for the clipped line rasterizer.
`timescale 1ns / 1ps
package clr_pkg;

  localparam int REQ_BITS   = 2;
  localparam int PIXEL_BITS = 16;
  localparam int COUNT_BITS = 7;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Request codes carried in req_type
  typedef enum logic [REQ_BITS-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LINE  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_code_t;

  // Background color after reset (RGB565)
  localparam pixel_t CLEAR_RESET = {8'h08, 8'h65};
  // Saturation point of the written pixel count
  localparam count_t COUNT_MAX   = {COUNT_BITS{1'b1}};

endpackage

/* hdl/clr_if.sv */
// Request and response channel interfaces of the clipped line rasterizer.
`timescale 1ns / 1ps
interface clr_req_if #(
  parameter int COORD_BITS = 10
);
  import clr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [REQ_BITS-1:0]          req_type;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  pixel_t                       line_color;

  modport source (
    output valid, req_type, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );
  modport sink (
    input  valid, req_type, start_x, start_y, end_x, end_y, line_color,
    output ready
  );
endinterface

interface clr_rsp_if;
  import clr_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t read_pixel;
  logic   read_inside;
  count_t written_count;

  modport source (
    output valid, read_pixel, read_inside, written_count,
    input  ready
  );
  modport sink (
    input  valid, read_pixel, read_inside, written_count,
    output ready
  );
endinterface

/* hdl/clr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module clr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/clipped_line_rasterizer.sv */
// Top level of the clipped line rasterizer: sequencer around one frame store RAM.
`timescale 1ns / 1ps
// Usage
//   req (sink) takes one request beat: clear, draw line or read pixel. rsp
//   (source) gives back exactly one result beat per request, in order.
//   cfg_wr_en/cfg_wr_data write the clear color; write it only while idle.
// Sequence, from the accepting edge to the result beat going valid:
//   clear : sweeps the whole store, one pixel written per cycle
//   line  : one Bresenham step per cycle over all points walked (the points
//           are the larger of |dx| and |dy| plus one)
//   read  : address cycle, registered RAM read, result load; off canvas skips
//   other : goes straight to the result
// The single write port of the frame store sets clear and line time; one
// request is worked at a time, so a new beat is taken once the last one
// has its result parked. The result sits in an output register, so req is
// taken again while rsp stalls; a second finished result waits in the done
// state until the output register frees up.
// Reset returns the controller to idle, drops rsp valid and loads the
// default clear color. The frame store is not initialized: clear it before
// reading.
module clipped_line_rasterizer #(
  parameter int CANVAS_W   = 100,
  parameter int CANVAS_H   = 100,
  parameter int COORD_BITS = 10
) (
  input  logic            clk,
  input  logic            rst,
  clr_req_if.sink         req,
  clr_rsp_if.source       rsp,
  input  logic            cfg_wr_en,
  input  clr_pkg::pixel_t cfg_wr_data
);
  import clr_pkg::*;

  localparam int DEPTH = CANVAS_W * CANVAS_H;
  localparam int AW    = $clog2(DEPTH);
  // Error term width: |err| stays below 2^(COORD_BITS+1), keep headroom
  localparam int EW    = COORD_BITS + 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_LINE,
    S_RD_ADDR,
    S_RD_DATA,
    S_DONE
  } state_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EW-1:0]         err_t;

  state_t          state;
  pixel_t          clear_color;

  // Walk registers: current point, end point, Bresenham terms
  coord_t          x0, y0, x1, y1;
  err_t            dx, dy, err;
  logic            step_x_pos, step_y_pos;
  pixel_t          color;
  count_t          count;
  logic [AW-1:0]   clr_addr;

  // Pending result, parked until the output register is free
  pixel_t          res_pixel;
  logic            res_inside;
  count_t          res_count;

  // Output register
  logic            rsp_valid;
  pixel_t          rsp_pixel;
  logic            rsp_inside;
  count_t          rsp_count;

  // RAM port signals
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  pixel_t          mem_wdata;
  pixel_t          mem_rdata;

  logic            pt_inside;
  logic [AW-1:0]   pt_addr;
  logic            start_inside;
  logic            at_end;
  logic signed [EW:0] e2;
  logic            do_x, do_y;
  err_t            err_next;
  count_t          count_next;
  err_t            sx_e, sy_e, ex_e, ey_e;
  err_t            dx_in, dy_in;

  function automatic logic on_canvas(coord_t x, coord_t y);
    return !x[COORD_BITS-1] && (32'(x[COORD_BITS-2:0]) < 32'(CANVAS_W)) &&
           !y[COORD_BITS-1] && (32'(y[COORD_BITS-2:0]) < 32'(CANVAS_H));
  endfunction

  // Row-major address of the current point; valid only when inside
  assign pt_inside = on_canvas(x0, y0);
  assign pt_addr   = AW'(32'(y0[COORD_BITS-2:0]) * 32'(CANVAS_W) +
                         32'(x0[COORD_BITS-2:0]));
  assign start_inside = on_canvas(req.start_x, req.start_y);

  // Bresenham step decision
  assign at_end   = (x0 == x1) && (y0 == y1);
  assign e2       = {err, 1'b0};
  assign do_x     = (e2 >= dy);
  assign do_y     = (e2 <= dx);
  assign err_next = err + (do_x ? dy : err_t'(0)) + (do_y ? dx : err_t'(0));
  assign count_next = (pt_inside && count != COUNT_MAX) ? count + count_t'(1) : count;

  // Line setup terms from the incoming beat
  assign sx_e  = EW'(req.start_x);
  assign sy_e  = EW'(req.start_y);
  assign ex_e  = EW'(req.end_x);
  assign ey_e  = EW'(req.end_y);
  assign dx_in = (ex_e > sx_e) ? ex_e - sx_e : sx_e - ex_e;
  assign dy_in = (ey_e > sy_e) ? sy_e - ey_e : ey_e - sy_e;

  // Frame store write: clear sweep or in-canvas line pixel
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pt_addr;
    mem_wdata = color;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = clear_color;
      end
      S_LINE: begin
        mem_we = pt_inside;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  clr_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (pt_addr),
    .rdata (mem_rdata)
  );

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.read_pixel    = rsp_pixel;
  assign rsp.read_inside   = rsp_inside;
  assign rsp.written_count = rsp_count;

  // Clear color register
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_color <= CLEAR_RESET;
    end else if (cfg_wr_en) begin
      clear_color <= cfg_wr_data;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the result once the sink takes it, unless the done state
      // refills the output register at this same edge
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_pixel  <= '0;
            res_inside <= 1'b0;
            res_count  <= '0;
            x0         <= req.start_x;
            y0         <= req.start_y;
            unique case (req_code_t'(req.req_type))
              REQ_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              REQ_LINE: begin
                x1         <= req.end_x;
                y1         <= req.end_y;
                dx         <= dx_in;
                dy         <= dy_in;
                err        <= dx_in + dy_in;
                step_x_pos <= (sx_e < ex_e);
                step_y_pos <= (sy_e < ey_e);
                color      <= req.line_color;
                count      <= '0;
                state      <= S_LINE;
              end
              REQ_READ: begin
                state <= start_inside ? S_RD_ADDR : S_DONE;
              end
              REQ_NONE: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_CLEAR: begin
          // Advance one pixel per cycle across the whole store
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_DONE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_LINE: begin
          count <= count_next;
          if (at_end) begin
            res_count <= count_next;
            state     <= S_DONE;
          end else begin
            err <= err_next;
            if (do_x) begin
              x0 <= step_x_pos ? x0 + coord_t'(1) : x0 - coord_t'(1);
            end
            if (do_y) begin
              y0 <= step_y_pos ? y0 + coord_t'(1) : y0 - coord_t'(1);
            end
          end
        end
        S_RD_ADDR: begin
          // RAM latches pt_addr at this edge
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          res_pixel  <= mem_rdata;
          res_inside <= 1'b1;
          state      <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free or being emptied
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_pixel  <= res_pixel;
            rsp_inside <= res_inside;
            rsp_count  <= res_count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Frame store is written only by the clear sweep or a line walk
  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_LINE))
    else $error("frame store written outside clear or line");

  // A pixel value is reported only for an in-canvas read
  a_pixel_only_inside: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.read_inside |-> rsp.read_pixel == '0)
    else $error("pixel returned for a point off the canvas");

  // Read and line results never mix
  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.written_count != '0 |-> !rsp.read_inside)
    else $error("result carries both a count and a read flag");

  // A pending result never overwrites an untaken one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ready |=> rsp_valid && $stable(rsp_pixel) &&
                                $stable(rsp_count))
    else $error("output register changed while stalled");

  // Read data is captured in the cycle after the address cycle
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    state == S_RD_ADDR |=> state == S_RD_DATA)
    else $error("read sequence broken");

endmodule

/* tb/tb_clipped_line_rasterizer.sv */
// Testbench for the clipped line rasterizer: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_clipped_line_rasterizer;
  import clr_pkg::*;

  localparam int CANVAS_W    = 100;
  localparam int CANVAS_H    = 100;
  localparam int COORD_BITS  = 10;
  localparam int PIXELS      = CANVAS_W * CANVAS_H;
  localparam int IDLE_PCT    = 21;
  localparam int PHASE_BEATS = 300;
  localparam int HOLD_CYCLES = 400;
  // Worst case is far below this: every item a full-range line of ~1024 steps,
  // a few dozen clears that each sweep the full store, plus idling on both sides.
  localparam int CYCLE_LIMIT = 5_000_000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    req_code_t kind;
    coord_t    sx;
    coord_t    sy;
    coord_t    ex;
    coord_t    ey;
    pixel_t    color;
  } raster_req_t;

  typedef struct {
    pixel_t pixel;
    logic   in_bounds;
    count_t count;
  } raster_rsp_t;

  // One row of the directed stimulus; typed rows carry a hand-written result.
  typedef struct {
    raster_req_t rq;
    bit          typed;
    raster_rsp_t want;
  } dir_row_t;

  logic   clk;
  logic   rst;
  logic   cfg_wr_en;
  pixel_t cfg_wr_data;

  clr_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
  clr_rsp_if                            rsp_bus ();

  clipped_line_rasterizer #(
    .CANVAS_W  (CANVAS_W),
    .CANVAS_H  (CANVAS_H),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state: our own copy of the frame store, a mask of pixels that
  // some clear or line has written, and the background color register.
  pixel_t      canvas_mem [PIXELS];
  bit          painted    [PIXELS];
  pixel_t      bg_color;

  raster_rsp_t awaited_results[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          no_idle;
  bit          hold_armed;

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: give up on a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic bit on_canvas(int x, int y);
    return x >= 0 && x < CANVAS_W && y >= 0 && y < CANVAS_H;
  endfunction

  // Work out the result of one accepted request and advance the frame store.
  function automatic raster_rsp_t rasterize_request(raster_req_t rq);
    raster_rsp_t r;
    int          x0, y0, x1, y1;
    int          dx, dy, step_x, step_y, err, e2;
    int unsigned plotted;
    r.pixel     = '0;
    r.in_bounds = 1'b0;
    r.count     = '0;
    x0 = rq.sx;
    y0 = rq.sy;
    x1 = rq.ex;
    y1 = rq.ey;
    case (rq.kind)
      REQ_CLEAR: begin
        for (int i = 0; i < PIXELS; i++) begin
          canvas_mem[i] = bg_color;
          painted[i]    = 1'b1;
        end
      end
      REQ_LINE: begin
        // Integer Bresenham over the full signed range; off-canvas steps
        // still walk but write nothing.
        dx      = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy      = (y1 > y0) ? y0 - y1 : y1 - y0;
        step_x  = (x0 < x1) ? 1 : -1;
        step_y  = (y0 < y1) ? 1 : -1;
        err     = dx + dy;
        plotted = 0;
        while (1) begin
          if (on_canvas(x0, y0)) begin
            canvas_mem[y0 * CANVAS_W + x0] = rq.color;
            painted[y0 * CANVAS_W + x0]    = 1'b1;
            if (plotted < COUNT_MAX) plotted++;
          end
          if (x0 == x1 && y0 == y1) break;
          e2 = 2 * err;
          if (e2 >= dy) begin
            err += dy;
            x0  += step_x;
          end
          if (e2 <= dx) begin
            err += dx;
            y0  += step_y;
          end
        end
        r.count = count_t'(plotted);
      end
      REQ_READ: begin
        if (on_canvas(x0, y0)) begin
          r.in_bounds = 1'b1;
          r.pixel     = canvas_mem[y0 * CANVAS_W + x0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic coord_t pick_coord(bit wide);
    if (wide) return coord_t'(int'($urandom_range(1023)) - 512);
    return coord_t'(int'($urandom_range(140)) - 20);
  endfunction

  // Mostly lines and reads around the canvas, a few full-range walks, rare
  // clears (each costs a full store sweep) and some unused request codes.
  function automatic raster_req_t random_request();
    raster_req_t rq;
    int unsigned pick;
    bit          wide;
    pick     = $urandom_range(99);
    wide     = ($urandom_range(99) < 20);
    rq.kind  = (pick < 2)  ? REQ_CLEAR :
               (pick < 52) ? REQ_LINE  :
               (pick < 92) ? REQ_READ  : REQ_NONE;
    rq.sx    = pick_coord(wide);
    rq.sy    = pick_coord(wide);
    rq.ex    = pick_coord(wide);
    rq.ey    = pick_coord(wide);
    rq.color = pixel_t'($urandom);
    // Never read a pixel that was never written; move such a read off canvas.
    if (rq.kind == REQ_READ && on_canvas(rq.sx, rq.sy) &&
        !painted[int'(rq.sy) * CANVAS_W + int'(rq.sx)])
      rq.sx = coord_t'(-1 - int'($urandom_range(511)));
    return rq;
  endfunction

  task automatic add_row(req_code_t kind, int sx, int sy, int ex, int ey, pixel_t color,
                         bit typed, pixel_t pix, logic ins, count_t cnt);
    dir_row_t row;
    row.rq.kind        = kind;
    row.rq.sx          = coord_t'(sx);
    row.rq.sy          = coord_t'(sy);
    row.rq.ex          = coord_t'(ex);
    row.rq.ey          = coord_t'(ey);
    row.rq.color       = color;
    row.typed          = typed;
    row.want.pixel     = pix;
    row.want.in_bounds = ins;
    row.want.count     = cnt;
    dir_rows.push_back(row);
  endtask

  // Offer one request beat, idling first at random, and record what it must
  // return once accepted. Valid stays high into the next beat unless we idle.
  task automatic send_request(raster_req_t rq, bit typed, raster_rsp_t want);
    raster_rsp_t predicted;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= rq.kind;
    req_bus.start_x    <= rq.sx;
    req_bus.start_y    <= rq.sy;
    req_bus.end_x      <= rq.ex;
    req_bus.end_y      <= rq.ey;
    req_bus.line_color <= rq.color;
    do @(posedge clk); while (!req_bus.ready);
    predicted = rasterize_request(rq);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_random();
    raster_rsp_t unused;
    unused.pixel     = '0;
    unused.in_bounds = 1'b0;
    unused.count     = '0;
    send_request(random_request(), 1'b0, unused);
  endtask

  // Drop valid, wait for every awaited result, then let the block settle.
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the background color; only called while the block is idle.
  task automatic set_clear_color(pixel_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    bg_color     = value;
  endtask

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Result checker: every response beat pairs with the oldest awaited result.
  always @(posedge clk) begin
    raster_rsp_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("unexpected beat, read_pixel", rsp_bus.read_pixel, 0);
      end else begin
        want = awaited_results.pop_front();
        if (rsp_bus.read_pixel !== want.pixel)
          flag_mismatch("read_pixel", rsp_bus.read_pixel, want.pixel);
        if (rsp_bus.read_inside !== want.in_bounds)
          flag_mismatch("read_inside", rsp_bus.read_inside, want.in_bounds);
        if (rsp_bus.written_count !== want.count)
          flag_mismatch("written_count", rsp_bus.written_count, want.count);
      end
    end
  end

  // Response side: random stalls, plus one long hold-off on request so the
  // block parks a result, finishes a second one and backs up its input.
  initial begin
    int hold_left;
    hold_left      = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    raster_req_t clear_rq;
    raster_rsp_t unused;
    pixel_t      phase_color;
    no_idle             = 1'b0;
    hold_armed          = 1'b0;
    bg_color            = CLEAR_RESET;
    unused.pixel        = '0;
    unused.in_bounds    = 1'b0;
    unused.count        = '0;
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    req_bus.valid      <= 1'b0;
    req_bus.req_type   <= '0;
    req_bus.start_x    <= '0;
    req_bus.start_y    <= '0;
    req_bus.end_x      <= '0;
    req_bus.end_y      <= '0;
    req_bus.line_color <= '0;

    // Directed rows. Reads ahead of the first clear stay off the canvas.
    add_row(REQ_READ,   -1,    0,    0,    0, 16'h0000, 1, 16'h0000,    0, 0);
    add_row(REQ_NONE,  511,  511,  511,  511, 16'hFFFF, 1, 16'h0000,    0, 0);
    add_row(REQ_NONE, -512, -512, -512, -512, 16'h0000, 1, 16'h0000,    0, 0);
    // Clear with the background color from reset, then read two corners and points off the canvas.
    add_row(REQ_CLEAR,  -1,   -1,   -1,   -1, 16'hFFFF, 1, 16'h0000,    0, 0);
    add_row(REQ_READ,    0,    0,    0,    0, 16'h0000, 1, CLEAR_RESET, 1, 0);
    add_row(REQ_READ,   99,   99,    0,    0, 16'h0000, 1, CLEAR_RESET, 1, 0);
    add_row(REQ_READ,  100,    0,    0,    0, 16'h0000, 1, 16'h0000,    0, 0);
    add_row(REQ_READ,    0,  100,    0,    0, 16'h0000, 1, 16'h0000,    0, 0);
    add_row(REQ_READ, -512, -512,    0,    0, 16'h0000, 1, 16'h0000,    0, 0);
    add_row(REQ_READ,  511,  511,    0,    0, 16'h0000, 1, 16'h0000,    0, 0);
    // Single-point lines, on and off the canvas.
    add_row(REQ_LINE,    5,    5,    5,    5, 16'hFFFF, 1, 16'h0000,    0, 1);
    add_row(REQ_READ,    5,    5,    0,    0, 16'h0000, 1, 16'hFFFF,    1, 0);
    add_row(REQ_LINE,   -1,   -1,   -1,   -1, 16'hFFFF, 1, 16'h0000,    0, 0);
    // Full edges and diagonal: one canvas side of pixels each.
    add_row(REQ_LINE,    0,    0,   99,    0, 16'h1234, 1, 16'h0000,    0, 100);
    add_row(REQ_LINE,    0,   99,    0,    0, 16'hF800, 1, 16'h0000,    0, 100);
    add_row(REQ_LINE,    0,    0,   99,   99, 16'h07E0, 1, 16'h0000,    0, 100);
    // Walks over the whole coordinate range, clipped to the canvas.
    add_row(REQ_LINE, -512, -512,  511,  511, 16'h001F, 1, 16'h0000,    0, 100);
    add_row(REQ_LINE, -512,   50,  511,   50, 16'h5555, 1, 16'h0000,    0, 100);
    add_row(REQ_LINE,   50,  511,   50, -512, 16'hAAAA, 1, 16'h0000,    0, 100);
    add_row(REQ_LINE,  511, -512, -512,  511, 16'hAAAA, 0, 16'h0000,    0, 0);
    // Steep, shallow reversed and partly clipped lines.
    add_row(REQ_LINE,   10,    0,   13,   99, 16'h0F0F, 0, 16'h0000,    0, 0);
    add_row(REQ_LINE,   99,   40,    0,   37, 16'hF0F0, 0, 16'h0000,    0, 0);
    add_row(REQ_LINE,  -30,  120,  130,  -10, 16'h3C3C, 0, 16'h0000,    0, 0);
    add_row(REQ_READ,   50,   50,    0,    0, 16'h0000, 0, 16'h0000,    0, 0);
    add_row(REQ_READ,   99,    0,    0,    0, 16'h0000, 0, 16'h0000,    0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

    // Random phases, each under its own background color: both extremes
    // first, then random values. Phase one runs with no idling anywhere;
    // phase two takes the long response hold-off.
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      phase_color = (phase == 0) ? 16'hFFFF :
                    (phase == 1) ? 16'h0000 : pixel_t'($urandom);
      set_clear_color(phase_color);
      no_idle        = (phase == 1);
      clear_rq       = random_request();
      clear_rq.kind  = REQ_CLEAR;
      send_request(clear_rq, 1'b0, unused);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (phase == 2 && n == 50) hold_armed = 1'b1;
        send_random();
      end
    end
    drain_results();
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* clipped_line_rasterizer.f */
hdl/clr_pkg.sv
hdl/clr_if.sv
hdl/clr_ram.sv
hdl/clipped_line_rasterizer.sv
tb/tb_clipped_line_rasterizer.sv
